[design/bts_pkg.sv]
// shared types and constants for the bus transmit self-test sequencer
`timescale 1ns / 1ps

package bts_pkg;

  // field widths
  localparam int TimeW    = 32;
  localparam int CntW     = 32;
  localparam int SpanW    = 16;
  localparam int TallyW   = 4;
  localparam int InDataW  = 248;
  localparam int OutDataW = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // remainder unit: four quotient bits per round, eight rounds for 32 bits
  localparam int DivBitsPerRound = 4;
  localparam int DivRounds       = TimeW / DivBitsPerRound;
  localparam int DivCntW         = $clog2(DivRounds);

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ATTEMPT_TOTAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PASS_MINIMUM  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM_TO    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP_MIN       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAP_SPAN      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FIRST_MIN     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FIRST_SPAN    = 3'd6;

  // register reset values
  localparam logic [TallyW-1:0] RST_ATTEMPT_TOTAL = 4'd5;
  localparam logic [TallyW-1:0] RST_PASS_MINIMUM  = 4'd3;
  localparam logic [SpanW-1:0]  RST_CONFIRM_TO    = 16'd1500;
  localparam logic [SpanW-1:0]  RST_GAP_MIN       = 16'd1000;
  localparam logic [SpanW-1:0]  RST_GAP_SPAN      = 16'd1000;
  localparam logic [SpanW-1:0]  RST_FIRST_MIN     = 16'd500;
  localparam logic [SpanW-1:0]  RST_FIRST_SPAN    = 16'd1500;

  // per-attempt outcome codes
  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_VERIFIED  = 3'd1,
    OUT_DIRTY     = 3'd2,
    OUT_NO_ECHO   = 3'd3,
    OUT_CONF_FAIL = 3'd4,
    OUT_TIMEOUT   = 3'd5,
    OUT_REFUSED   = 3'd6
  } outcome_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic div_init;
    logic div_step;
    logic commit;
  } bts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
  } bts_status_t;

endpackage

[design/bts_ctrl.sv]
// controller state machine: word handshakes and sequencing of the datapath
`timescale 1ns / 1ps

module bts_ctrl
  import bts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  bts_status_t status,
  output bts_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [DivCntW-1:0]   cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.load      = in_tvalid && (state_r == S_IDLE);
    cmd.eval      = (state_r == S_EVAL);
    cmd.div_init  = (state_r == S_EVAL);
    cmd.div_step  = (state_r == S_DIV);
    cmd.commit    = (state_r == S_COMMIT) && (!out_valid_r || out_tready);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cnt_nxt   = '0;
        state_nxt = status.need_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivRounds - 1)) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // output word valid: set on commit, cleared when taken
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/bts_dpath.sv]
// datapath: config registers, test state, attempt evaluation, remainder unit
`timescale 1ns / 1ps

module bts_dpath
  import bts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  bts_cmd_t            cmd,
  output bts_status_t         status,
  output logic [OutDataW-1:0] out_tdata
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DELAY,
    PH_CONFIRM,
    PH_DONE
  } phase_t;

  // registered evaluation of one word
  typedef struct packed {
    logic                 start_go;
    logic                 fire;
    logic                 accepted;
    logic                 conf_hit;
    logic                 clean;
    logic                 close;
    logic                 close_done;
    outcome_t             outcome;
    logic [TimeW-1:0]     base;
    logic [SpanW-1:0]     span;
  } eval_t;

  // config registers
  logic [TallyW-1:0] attempt_total_r, pass_minimum_r;
  logic [SpanW-1:0]  confirm_to_r, gap_min_r, gap_span_r, first_min_r, first_span_r;

  // test state
  phase_t            phase_r, phase_nxt;
  logic [TallyW-1:0] sent_r, sent_nxt, good_r, good_nxt;
  logic [TimeW-1:0]  deadline_r, deadline_nxt, conf_begin_r, conf_begin_nxt;
  logic [CntW-1:0]   snap_done_r, snap_ok_r, snap_echo_r, snap_bad_r, snap_odd_r;
  logic              mode_r, mode_nxt;

  // captured input word
  logic              cap_func_r;
  logic [TimeW-1:0]  cap_now_r;
  logic [CntW-1:0]   cap_done_r, cap_ok_r, cap_echo_r, cap_bad_r, cap_odd_r;
  logic              cap_acc_r;
  logic [15:0]       cap_pay_r;
  logic [TimeW-1:0]  cap_rnd_r;

  eval_t             ev_c, ev_r;
  logic [SpanW-1:0]  rem_r, rem_c, mod_val;
  logic [TimeW-1:0]  quo_r, quo_c;
  logic [SpanW:0]    trial;
  logic [TallyW-1:0] sent_inc, sent_new;
  logic [TimeW-1:0]  elapsed;
  logic              ok_up, echo_up, done_up, in_conf;
  logic [OutDataW-1:0] out_r, out_nxt;
  logic              req_o, running_o, finished_o, passed_o;
  logic [7:0]        p0_o, p1_o;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_total_r <= RST_ATTEMPT_TOTAL;
      pass_minimum_r  <= RST_PASS_MINIMUM;
      confirm_to_r    <= RST_CONFIRM_TO;
      gap_min_r       <= RST_GAP_MIN;
      gap_span_r      <= RST_GAP_SPAN;
      first_min_r     <= RST_FIRST_MIN;
      first_span_r    <= RST_FIRST_SPAN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTEMPT_TOTAL: attempt_total_r <= cfg_data[TallyW-1:0];
        REG_PASS_MINIMUM:  pass_minimum_r  <= cfg_data[TallyW-1:0];
        REG_CONFIRM_TO:    confirm_to_r    <= cfg_data;
        REG_GAP_MIN:       gap_min_r       <= cfg_data;
        REG_GAP_SPAN:      gap_span_r      <= cfg_data;
        REG_FIRST_MIN:     first_min_r     <= cfg_data;
        REG_FIRST_SPAN:    first_span_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_func_r <= in_tuser;
      cap_now_r  <= in_tdata[31:0];
      cap_done_r <= in_tdata[63:32];
      cap_ok_r   <= in_tdata[95:64];
      cap_echo_r <= in_tdata[127:96];
      cap_bad_r  <= in_tdata[159:128];
      cap_odd_r  <= in_tdata[191:160];
      cap_acc_r  <= in_tdata[192];
      cap_pay_r  <= in_tdata[208:193];
      cap_rnd_r  <= in_tdata[240:209];
    end
  end

  // attempt evaluation: time and counter compares
  always_comb begin
    ok_up    = cap_ok_r > snap_ok_r;
    echo_up  = cap_echo_r > snap_echo_r;
    done_up  = cap_done_r > snap_done_r;
    elapsed  = cap_now_r - conf_begin_r;
    in_conf  = !cap_func_r && (phase_r == PH_CONFIRM);
    sent_inc = sent_r + 1'b1;

    ev_c          = '0;
    ev_c.start_go = cap_func_r && (phase_r == PH_IDLE || phase_r == PH_DONE);
    ev_c.fire     = !cap_func_r && (phase_r == PH_DELAY) && (cap_now_r >= deadline_r);
    ev_c.accepted = cap_acc_r;
    ev_c.conf_hit = in_conf && ok_up && echo_up;
    ev_c.clean    = (cap_bad_r == snap_bad_r) && (cap_odd_r == snap_odd_r);
    ev_c.close    = (ev_c.fire && !cap_acc_r) || ev_c.conf_hit ||
                    (in_conf && !(ok_up && echo_up) &&
                     (elapsed >= {{(TimeW-SpanW){1'b0}}, confirm_to_r}));
    sent_new        = ev_c.fire ? sent_inc : sent_r;
    ev_c.close_done = sent_new >= attempt_total_r;

    // outcome classification
    if (ev_c.fire && !cap_acc_r) begin
      ev_c.outcome = OUT_REFUSED;
    end else if (ev_c.conf_hit) begin
      ev_c.outcome = ev_c.clean ? OUT_VERIFIED : OUT_DIRTY;
    end else if (ev_c.close) begin
      if (ok_up) begin
        ev_c.outcome = OUT_NO_ECHO;
      end else if (done_up) begin
        ev_c.outcome = OUT_CONF_FAIL;
      end else begin
        ev_c.outcome = OUT_TIMEOUT;
      end
    end else begin
      ev_c.outcome = OUT_NONE;
    end

    // delay base and span for the next deadline
    ev_c.base = cap_now_r + {{(TimeW-SpanW){1'b0}},
                             (ev_c.start_go ? first_min_r : gap_min_r)};
    ev_c.span = ev_c.start_go ? first_span_r : gap_span_r;

    status.need_div = ev_c.start_go || (ev_c.close && !ev_c.close_done);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) ev_r <= ev_c;
  end

  // remainder unit: restoring, a few quotient bits per round
  always_comb begin
    rem_c = rem_r;
    quo_c = quo_r;
    trial = '0;
    for (int i = 0; i < DivBitsPerRound; i++) begin
      trial = {rem_c, quo_c[TimeW-1]};
      quo_c = {quo_c[TimeW-2:0], 1'b0};
      if (trial >= {1'b0, ev_r.span}) begin
        rem_c = SpanW'(trial - {1'b0, ev_r.span});
      end else begin
        rem_c = trial[SpanW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= cap_rnd_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_c;
      quo_r <= quo_c;
    end
  end

  // a zero span gives no random part
  assign mod_val = (ev_r.span == '0) ? '0 : rem_r;

  // next test state and result word
  always_comb begin
    phase_nxt      = phase_r;
    sent_nxt       = sent_r;
    good_nxt       = good_r;
    deadline_nxt   = deadline_r;
    conf_begin_nxt = conf_begin_r;
    mode_nxt       = mode_r;

    if (ev_r.start_go) begin
      sent_nxt     = '0;
      good_nxt     = '0;
      mode_nxt     = 1'b1;
      phase_nxt    = PH_DELAY;
      deadline_nxt = ev_r.base + {{(TimeW-SpanW){1'b0}}, mod_val};
    end
    if (ev_r.fire) begin
      sent_nxt = sent_r + 1'b1;
      if (ev_r.accepted) begin
        conf_begin_nxt = cap_now_r;
        phase_nxt      = PH_CONFIRM;
      end
    end
    if (ev_r.conf_hit && ev_r.clean) good_nxt = good_r + 1'b1;
    if (ev_r.close) begin
      if (ev_r.close_done) begin
        phase_nxt = PH_DONE;
        mode_nxt  = 1'b0;
      end else begin
        phase_nxt    = PH_DELAY;
        deadline_nxt = ev_r.base + {{(TimeW-SpanW){1'b0}}, mod_val};
      end
    end

    req_o      = ev_r.fire;
    p0_o       = ev_r.fire ? cap_pay_r[7:0] : 8'd0;
    p1_o       = ev_r.fire ? ({4'd0, sent_r} ^ cap_pay_r[15:8]) : 8'd0;
    running_o  = (phase_nxt == PH_DELAY) || (phase_nxt == PH_CONFIRM);
    finished_o = (phase_nxt == PH_DONE);
    passed_o   = finished_o && (good_nxt >= pass_minimum_r);
    out_nxt    = {passed_o, finished_o, running_o, mode_nxt, good_nxt, sent_nxt,
                  ev_r.outcome, p1_o, p0_o, req_o};
  end

  // test state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      sent_r       <= '0;
      good_r       <= '0;
      deadline_r   <= '0;
      conf_begin_r <= '0;
      snap_done_r  <= '0;
      snap_ok_r    <= '0;
      snap_echo_r  <= '0;
      snap_bad_r   <= '0;
      snap_odd_r   <= '0;
      mode_r       <= 1'b0;
    end else if (cmd.commit) begin
      phase_r      <= phase_nxt;
      sent_r       <= sent_nxt;
      good_r       <= good_nxt;
      deadline_r   <= deadline_nxt;
      conf_begin_r <= conf_begin_nxt;
      mode_r       <= mode_nxt;
      if (ev_r.fire) begin
        snap_done_r <= cap_done_r;
        snap_ok_r   <= cap_ok_r;
        snap_echo_r <= cap_echo_r;
        snap_bad_r  <= cap_bad_r;
        snap_odd_r  <= cap_odd_r;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

[design/bus_transmit_self_test_sequencer.sv]
// Factory self-test sequencer for a bus transmitter (top level).
// Input channel in_*: one word per start request (in_tuser=1) or poll tick
// (in_tuser=0) carrying time, five transceiver counters, the send-accepted
// flag and random bits. Each input word yields exactly one output word on
// out_* with the send request, payload bytes, attempt outcome, tallies and
// run status. cfg_* writes one of seven registers; it is always ready and is
// to be used only while the block is idle.
// Each word is evaluated and then committed; when a new deadline is
// scheduled, the random delay needs rand_delay mod span, computed in between
// by a restoring remainder unit at 4 bits per cycle.
// One word is processed at a time, so no new word is taken before the last
// one is committed; in_tready is high only while the controller is idle.
// The output word is held in a register, so the next input word is taken
// while the previous result waits; if out_tready stays low, the block stalls
// at its commit step until the output register is free.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// tallies and snapshots, returns to idle and drops out_tvalid.
`timescale 1ns / 1ps

module bus_transmit_self_test_sequencer
  import bts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata from bit 0: now_ms[31:0], tx_done_count[63:32], tx_ok_count[95:64],
  // echo_count[127:96], bad_frame_count[159:128], odd_control_count[191:160],
  // send_accepted[192], rand_payload[208:193], rand_delay[240:209], zero pad
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,   // func
  input  logic                in_tvalid,
  output logic                in_tready,
  // out_tdata from bit 0: send_request[0], payload_first[8:1],
  // payload_second[16:9], outcome[19:17], attempts_made[23:20],
  // verified_count[27:24], test_mode[28], running[29], finished[30], passed[31]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  bts_cmd_t    cmd;
  bts_status_t status;

  assign cfg_ready = 1'b1;

  bts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

[design/bts_checker.sv]
// port-level checks for the self-test sequencer, bound to the top level
`timescale 1ns / 1ps

module bts_checker
  import bts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tvalid,
  input logic                out_tready
);

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // one word at a time: no acceptance right after an acceptance
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  // test mode is raised exactly while a run is active
  a_mode_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28] == out_tdata[29]))
    else $error("test mode disagrees with running");

  // pass only when finished, and no payload without a send
  a_pass_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[31] || out_tdata[30]) &&
                   (out_tdata[0] || (out_tdata[16:1] == 16'd0)))
    else $error("pass without finish or payload without send");

endmodule

bind bus_transmit_self_test_sequencer bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[tb/tb.sv]
// testbench for the bus transmit self-test sequencer: directed rows, then random runs per setting
`timescale 1ns / 1ps

module tb;
  import bts_pkg::*;

  localparam int RandomWords = 1630;
  localparam int SettingSets = 6;
  localparam int CalmWords   = 150;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 16;

  typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_CONFIRM, PH_DONE} run_phase_t;

  // input word, odd_control_count down to now_ms, pad on top
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] rdel;
    logic [15:0] rpay;
    logic        acc;
    logic [31:0] odd, bad, echo, ok, done, now;
  } poll_t;

  // status word, passed on top down to send_request in bit 0
  typedef struct packed {
    logic        passed;
    logic        finished;
    logic        running;
    logic        test_mode;
    logic [3:0]  verified;
    logic [3:0]  attempts;
    outcome_t    outcome;
    logic [7:0]  p_second;
    logic [7:0]  p_first;
    logic        send_req;
  } status_t;

  typedef struct {
    logic    func;
    poll_t   w;
    logic    typed;
    status_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  bus_transmit_self_test_sequencer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted sequencer registers and state
  logic [3:0]  att_total = RST_ATTEMPT_TOTAL;
  logic [3:0]  pass_min = RST_PASS_MINIMUM;
  logic [15:0] confirm_to = RST_CONFIRM_TO;
  logic [15:0] gap_min = RST_GAP_MIN;
  logic [15:0] gap_span = RST_GAP_SPAN;
  logic [15:0] first_min = RST_FIRST_MIN;
  logic [15:0] first_span = RST_FIRST_SPAN;
  run_phase_t  ph = PH_IDLE;
  logic [3:0]  sent = '0;
  logic [3:0]  good = '0;
  logic [31:0] deadline = '0;
  logic [31:0] cbegin = '0;
  logic [31:0] snap_done = '0, snap_ok = '0, snap_echo = '0, snap_bad = '0, snap_odd = '0;
  logic        mode = 1'b0;

  status_t     expected_status[$];
  dir_row_t    dir_rows[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned runs_passed = 0;
  int unsigned outcome_seen[7];
  bit          idle_ok = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [31:0] delay_pick(logic [15:0] lo, logic [15:0] span,
                                             logic [31:0] rnd);
    return {16'd0, lo} + ((span != 16'd0) ? rnd % {16'd0, span} : 32'd0);
  endfunction

  // after an attempt: finish the run or schedule the next telegram
  task automatic close_attempt(input logic [31:0] now, input logic [31:0] rnd);
    if (sent >= att_total) begin
      ph = PH_DONE;
      mode = 1'b0;
    end else begin
      deadline = now + delay_pick(gap_min, gap_span, rnd);
      ph = PH_DELAY;
    end
  endtask

  task automatic predict_status(input logic f, input poll_t w, output status_t r);
    logic [31:0] elapsed;
    r = '0;
    r.outcome = OUT_NONE;
    if (f) begin
      if (ph == PH_IDLE || ph == PH_DONE) begin
        sent = '0;
        good = '0;
        mode = 1'b1;
        ph = PH_DELAY;
        deadline = w.now + delay_pick(first_min, first_span, w.rdel);
      end
    end else if (ph == PH_DELAY) begin
      if (w.now >= deadline) begin
        snap_done = w.done; snap_ok = w.ok; snap_echo = w.echo;
        snap_bad = w.bad; snap_odd = w.odd;
        r.send_req = 1'b1;
        r.p_first = w.rpay[7:0];
        r.p_second = {4'd0, sent} ^ w.rpay[15:8];
        sent = sent + 4'd1;
        if (w.acc) begin
          cbegin = w.now;
          ph = PH_CONFIRM;
        end else begin
          r.outcome = OUT_REFUSED;
          close_attempt(w.now, w.rdel);
        end
      end
    end else if (ph == PH_CONFIRM) begin
      elapsed = w.now - cbegin;
      if (w.ok > snap_ok && w.echo > snap_echo) begin
        if (w.bad == snap_bad && w.odd == snap_odd) begin
          good = good + 4'd1;
          r.outcome = OUT_VERIFIED;
        end else begin
          r.outcome = OUT_DIRTY;
        end
        close_attempt(w.now, w.rdel);
      end else if (elapsed >= {16'd0, confirm_to}) begin
        if (w.ok > snap_ok) r.outcome = OUT_NO_ECHO;
        else if (w.done > snap_done) r.outcome = OUT_CONF_FAIL;
        else r.outcome = OUT_TIMEOUT;
        close_attempt(w.now, w.rdel);
      end
    end
    r.attempts = sent;
    r.verified = good;
    r.test_mode = mode;
    r.running = (ph == PH_DELAY || ph == PH_CONFIRM);
    r.finished = (ph == PH_DONE);
    r.passed = (ph == PH_DONE) && (good >= pass_min);
  endtask

  function automatic status_t mk_res(logic req, logic [7:0] p0, logic [7:0] p1, outcome_t oc,
                                     logic [3:0] att, logic [3:0] ver, logic tm, logic run,
                                     logic fin, logic pas);
    status_t r;
    r.send_req = req; r.p_first = p0; r.p_second = p1; r.outcome = oc;
    r.attempts = att; r.verified = ver; r.test_mode = tm; r.running = run;
    r.finished = fin; r.passed = pas;
    return r;
  endfunction

  task automatic add_row(input logic f, input logic [31:0] now, input logic [31:0] done,
                         input logic [31:0] ok, input logic [31:0] echo,
                         input logic [31:0] bad, input logic [31:0] odd, input logic acc,
                         input logic [15:0] rpay, input logic [31:0] rdel,
                         input logic typed, input status_t res);
    dir_row_t row;
    row.func = f;
    row.w = '{pad: '0, rdel: rdel, rpay: rpay, acc: acc, odd: odd, bad: bad, echo: echo,
              ok: ok, done: done, now: now};
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // counter value relative to a snapshot: unchanged, one up, far up or anywhere
  function automatic logic [31:0] bump(logic [31:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return base;
      4, 5, 6, 7: return base + 32'd1;
      8:          return base + $urandom_range(2, 1000);
      default:    return $urandom;
    endcase
  endfunction

  // mostly well-formed polls steered by the predicted phase, some noise
  task automatic make_word(output logic f, output poll_t w);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    f = 1'b0;
    w.pad = '0;
    w.now = $urandom; w.done = $urandom; w.ok = $urandom; w.echo = $urandom;
    w.bad = $urandom; w.odd = $urandom;
    w.acc = 1'($urandom_range(0, 1));
    w.rpay = 16'($urandom_range(0, 65535));
    w.rdel = $urandom;
    case (ph)
      PH_IDLE, PH_DONE: f = (pick < 70);
      PH_DELAY: begin
        if (pick < 3) f = 1'b1;
        else if (pick < 65) w.now = deadline + $urandom_range(0, 2);
        else if (pick < 80) w.now = deadline - $urandom_range(1, 3);
        w.acc = ($urandom_range(0, 7) != 0);
        if (pick >= 95) begin
          w.done = '1; w.ok = '1; w.echo = '1; w.bad = '1; w.odd = '1;
        end
      end
      default: begin
        if (pick < 3) f = 1'b1;
        else if (pick < 92) begin
          w.done = bump(snap_done);
          w.ok = bump(snap_ok);
          w.echo = bump(snap_echo);
          w.bad = ($urandom_range(0, 4) == 0) ? bump(snap_bad) : snap_bad;
          w.odd = ($urandom_range(0, 4) == 0) ? bump(snap_odd) : snap_odd;
          case ($urandom_range(0, 3))
            0:       w.now = cbegin + $urandom_range(0, confirm_to);
            1:       w.now = cbegin + confirm_to - 32'd1;
            2:       w.now = cbegin + confirm_to;
            default: w.now = cbegin + confirm_to + $urandom_range(1, 100000);
          endcase
        end
      end
    endcase
  endtask

  // optional input gap, then hold the word until taken and record its status
  task automatic drive_word(input logic f, input poll_t w, input logic typed,
                            input status_t fixed);
    status_t r;
    if (idle_ok && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tuser <= f;
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_status(f, w, r);
    expected_status.push_back(typed ? fixed : r);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ATTEMPT_TOTAL: att_total = data[3:0];
      REG_PASS_MINIMUM:  pass_min = data[3:0];
      REG_CONFIRM_TO:    confirm_to = data;
      REG_GAP_MIN:       gap_min = data;
      REG_GAP_SPAN:      gap_span = data;
      REG_FIRST_MIN:     first_min = data;
      REG_FIRST_SPAN:    first_span = data;
      default: ;
    endcase
  endtask

  // register sets: smallest, largest, zero spans with zero attempts, then random
  task automatic load_settings(input int k);
    logic [15:0] v[7];
    case (k)
      1: v = '{16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1};
      2: v = '{16'd15, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      3: v = '{16'd0, 16'd1, 16'($urandom_range(1, 3000)), 16'($urandom_range(0, 2000)),
               16'd0, 16'($urandom_range(0, 2000)), 16'd0};
      default: begin
        v[0] = 16'($urandom_range(0, 65535));
        v[1] = 16'($urandom_range(0, 65535));
        for (int i = 2; i < 7; i++) v[i] = 16'($urandom_range(0, 65535));
      end
    endcase
    write_reg(REG_ATTEMPT_TOTAL, v[0]);
    write_reg(REG_PASS_MINIMUM, v[1]);
    write_reg(REG_CONFIRM_TO, v[2]);
    write_reg(REG_GAP_MIN, v[3]);
    write_reg(REG_GAP_SPAN, v[4]);
    write_reg(REG_FIRST_MIN, v[5]);
    write_reg(REG_FIRST_SPAN, v[6]);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, nm, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_status
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata);
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected status word, expected none got %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_status.pop_front();
        check_field("send_request", want.send_req, got.send_req);
        check_field("payload_first", want.p_first, got.p_first);
        check_field("payload_second", want.p_second, got.p_second);
        check_field("outcome", want.outcome, got.outcome);
        check_field("attempts_made", want.attempts, got.attempts);
        check_field("verified_count", want.verified, got.verified);
        check_field("test_mode", want.test_mode, got.test_mode);
        check_field("running", want.running, got.running);
        check_field("finished", want.finished, got.finished);
        check_field("passed", want.passed, got.passed);
        outcome_seen[want.outcome]++;
        if (want.passed && want.outcome != OUT_NONE) runs_passed++;
        results_seen++;
      end
    end
  end

  // output backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_ok && out_tready && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("bus_transmit_self_test_sequencer test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic    f;
    poll_t   w;
    int      n;
    int      per_set;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed run under the reset register values
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_NONE, 0, 0, 0, 0, 0, 0));
    add_row(0, '1, '1, '1, '1, '1, '1, 1, 16'hFFFF, '1, 1,
            mk_res(0, 0, 0, OUT_NONE, 0, 0, 0, 0, 0, 0));
    add_row(1, 100, 0, 0, 0, 0, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_NONE, 0, 0, 1, 1, 0, 0));
    // start while running is ignored
    add_row(1, 5, 0, 0, 0, 0, 0, 1, 16'h1234, '1, 1,
            mk_res(0, 0, 0, OUT_NONE, 0, 0, 1, 1, 0, 0));
    add_row(0, 599, 0, 0, 0, 0, 0, 1, 16'h1234, 0, 1,
            mk_res(0, 0, 0, OUT_NONE, 0, 0, 1, 1, 0, 0));
    add_row(0, 600, 10, 20, 30, 0, 0, 1, 16'hA55A, 0, 1,
            mk_res(1, 8'h5A, 8'hA5, OUT_NONE, 1, 0, 1, 1, 0, 0));
    add_row(0, 700, 10, 21, 31, 0, 0, 0, 16'h0000, 1234, 1,
            mk_res(0, 0, 0, OUT_VERIFIED, 1, 1, 1, 1, 0, 0));
    add_row(0, 1934, 11, 21, 31, 0, 0, 1, 16'hFFFF, 0, 1,
            mk_res(1, 8'hFF, 8'hFE, OUT_NONE, 2, 1, 1, 1, 0, 0));
    add_row(0, 2000, 11, 22, 32, 1, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_DIRTY, 2, 1, 1, 1, 0, 0));
    add_row(0, 3000, 12, 22, 32, 1, 0, 1, 16'h0000, 0, 1,
            mk_res(1, 0, 8'h02, OUT_NONE, 3, 1, 1, 1, 0, 0));
    add_row(0, 4499, 12, 23, 32, 1, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_NONE, 3, 1, 1, 1, 0, 0));
    add_row(0, 4500, 12, 23, 32, 1, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_NO_ECHO, 3, 1, 1, 1, 0, 0));
    add_row(0, 5500, 13, 23, 33, 1, 0, 1, 16'h0000, 0, 1,
            mk_res(1, 0, 8'h03, OUT_NONE, 4, 1, 1, 1, 0, 0));
    add_row(0, 7000, 14, 23, 33, 1, 0, 0, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_CONF_FAIL, 4, 1, 1, 1, 0, 0));
    // last send refused ends the run and drops test mode
    add_row(0, 8000, 14, 23, 33, 1, 0, 0, 16'h0000, 0, 1,
            mk_res(1, 0, 8'h04, OUT_REFUSED, 5, 1, 0, 0, 1, 0));
    add_row(0, 9000, 0, 0, 0, 0, 0, 1, 16'h0000, 0, 1,
            mk_res(0, 0, 0, OUT_NONE, 5, 1, 0, 0, 1, 0));
    // deadline wraps past 2^32, then elapsed time wraps as well
    add_row(1, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 16'h0000, '1, 0, '0);
    add_row(0, '1, '1, '1, '1, '1, '1, 1, 16'h00FF, '1, 0, '0);
    add_row(0, 5, '1, '1, '1, '1, '1, 0, 16'h0000, 0, 0, '0);
    add_row(0, 1499, '1, '1, '1, '1, '1, 0, 16'h0000, 7, 0, '0);
    foreach (dir_rows[i])
      drive_word(dir_rows[i].func, dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    // random runs, one block per register set
    per_set = RandomWords / SettingSets;
    n = 0;
    for (int k = 0; k < SettingSets; k++) begin
      if (k > 0) begin
        drain();
        load_settings(k);
      end
      for (int j = 0; j < per_set; j++) begin
        idle_ok = (n < RandomWords - CalmWords) && ((n / 80) % 3 != 2);
        make_word(f, w);
        drive_word(f, w, 1'b0, '0);
        n++;
      end
    end
    idle_ok = 1'b0;
    drain();

    $display("covered %0d words (%0d directed) over %0d register sets, %0d results checked",
             words_sent, dir_rows.size(), SettingSets, results_seen);
    $display("outcomes none %0d verified %0d dirty %0d no-echo %0d confirm-fail %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    $display("outcomes timeout %0d refused %0d, passing runs %0d",
             outcome_seen[5], outcome_seen[6], runs_passed);
    if (errors == 0)
      $display("bus_transmit_self_test_sequencer test passed");
    else
      $display("bus_transmit_self_test_sequencer test failed");
    $finish;
  end

endmodule

[filelist.f]
design/bts_pkg.sv
design/bts_ctrl.sv
design/bts_dpath.sv
design/bus_transmit_self_test_sequencer.sv
design/bts_checker.sv
tb/tb.sv
